@@ rtl/location_range_table_macros.svh @@
// Assertion macros for the location range table.
`ifndef LOCATION_RANGE_TABLE_MACROS_SVH
`define LOCATION_RANGE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

`define LRT_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lrt: forbidden condition seen");

`define LRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrt: expected follow-up missing");

`else

`define LRT_ASSERT_NEVER(label, clk, rst_n, cond)

`define LRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/lrt_pkg.sv @@
// Shared types and codes for the location range table.
`timescale 1ns / 1ps

package lrt_pkg;

    localparam int LocW = 32;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_LOOKUP = 1'b1
    } req_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } lrt_state_t;

    typedef struct packed {
        logic            vld;
        logic            found;
        logic [LocW-1:0] loc;
        logic [LocW-1:0] start;
        logic [LocW-1:0] lim;
    } lrt_link_t;

endpackage

@@ rtl/lrt_cell.sv @@
// One table entry: holds a range end and advances the lookup transaction by one step.
`timescale 1ns / 1ps

module lrt_cell #(
    parameter int IdW = 9,
    parameter int IDX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [lrt_pkg::LocW-1:0] wdata,
    input  lrt_pkg::lrt_link_t       link_in,
    input  logic [IdW-1:0]           id_in,
    output lrt_pkg::lrt_link_t       link_out,
    output logic [IdW-1:0]           id_out
);
    import lrt_pkg::*;

    logic [LocW-1:0] end_reg;
    lrt_link_t       link_reg;
    lrt_link_t       link_next;
    logic [IdW-1:0]  id_reg;
    logic [IdW-1:0]  id_next;
    logic            hit;

    assign hit = link_in.vld && !link_in.found && (link_in.loc < end_reg);

    always_comb
    begin
        link_next.vld   = link_in.vld;
        link_next.found = link_in.found || hit;
        link_next.loc   = link_in.loc;
        link_next.start = (link_in.found || hit) ? link_in.start : end_reg;
        link_next.lim   = hit ? end_reg : link_in.lim;
        id_next         = hit ? IdW'(IDX + 1) : id_in;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            end_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
            id_reg   <= '0;
        end
        else
        begin
            link_reg <= link_next;
            id_reg   <= id_next;
        end
    end

    assign link_out = link_reg;
    assign id_out   = id_reg;

endmodule

@@ rtl/location_range_table.sv @@
// Top level: contiguous range table with last-hit cache and a cell chain for lookups.
// Append, cache hit and out-of-range lookup: result registered in the next cycle, busy stays low.
// Lookup that misses the cache: result registered once the query leaves the last cell, busy high
// while the query walks the chain of MAX_ENTRIES cells, one cell a cycle.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset clears entry count, cache and chain; table contents stay undefined, no clearing pass.
`timescale 1ns / 1ps

module location_range_table #(
    parameter int MAX_ENTRIES = 256,
    localparam int IdW        = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic [lrt_pkg::LocW-1:0] entry_size,
    input  logic [lrt_pkg::LocW-1:0] location,
    output logic                     done,
    output lrt_pkg::status_t         status,
    output logic [IdW-1:0]           file_id,
    output logic [lrt_pkg::LocW-1:0] range_start,
    output logic [lrt_pkg::LocW-1:0] offset_in_range
);
    import lrt_pkg::*;

`include "location_range_table_macros.svh"

    lrt_state_t      state_reg;
    lrt_state_t      state_next;
    logic [IdW-1:0]  count_reg;
    logic [IdW-1:0]  count_next;
    logic [LocW-1:0] last_end_reg;
    logic [LocW-1:0] last_end_next;
    logic [LocW-1:0] cached_start_reg;
    logic [LocW-1:0] cached_start_next;
    logic [LocW-1:0] cached_end_reg;
    logic [LocW-1:0] cached_end_next;
    logic [IdW-1:0]  cached_id_reg;
    logic [IdW-1:0]  cached_id_next;
    logic            done_reg;
    logic            done_next;
    status_t         status_reg;
    status_t         status_next;
    logic [IdW-1:0]  id_reg;
    logic [IdW-1:0]  id_next;
    logic [LocW-1:0] rstart_reg;
    logic [LocW-1:0] rstart_next;
    logic [LocW-1:0] offset_reg;
    logic [LocW-1:0] offset_next;

    logic            accept;
    logic            launch;
    logic            we_app;
    logic            full;
    logic            cache_hit;
    logic            outside;
    logic [LocW:0]   sum;

    lrt_link_t       link  [0:MAX_ENTRIES];
    logic [IdW-1:0]  id_lk [0:MAX_ENTRIES];
    lrt_link_t       tail;
    logic [IdW-1:0]  tail_id;

    assign accept    = start && !busy;
    assign full      = (count_reg == IdW'(MAX_ENTRIES));
    assign sum       = {1'b0, last_end_reg} + {1'b0, entry_size} + {{LocW{1'b0}}, 1'b1};
    assign cache_hit = (location >= cached_start_reg) && (location < cached_end_reg);
    assign outside   = (location >= last_end_reg);
    assign tail      = link[MAX_ENTRIES];
    assign tail_id   = id_lk[MAX_ENTRIES];

    always_comb
    begin
        done_next         = 1'b0;
        status_next       = status_reg;
        id_next           = id_reg;
        rstart_next       = rstart_reg;
        offset_next       = offset_reg;
        count_next        = count_reg;
        last_end_next     = last_end_reg;
        cached_start_next = cached_start_reg;
        cached_end_next   = cached_end_reg;
        cached_id_next    = cached_id_reg;
        we_app            = 1'b0;
        launch            = 1'b0;
        if (accept)
        begin
            if (req_type == REQ_APPEND)
            begin
                done_next = 1'b1;
                if (full)
                begin
                    status_next = ST_FULL;
                    id_next     = '0;
                    rstart_next = '0;
                    offset_next = '0;
                end
                else if (sum[LocW])
                begin
                    status_next = ST_OVERFLOW;
                    id_next     = '0;
                    rstart_next = last_end_reg;
                    offset_next = '0;
                end
                else
                begin
                    status_next   = ST_OK;
                    id_next       = count_reg + 1'b1;
                    rstart_next   = last_end_reg;
                    offset_next   = '0;
                    count_next    = count_reg + 1'b1;
                    last_end_next = sum[LocW-1:0];
                    we_app        = 1'b1;
                end
            end
            else if (cache_hit)
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                id_next     = cached_id_reg;
                rstart_next = cached_start_reg;
                offset_next = location - cached_start_reg;
            end
            else if (outside)
            begin
                done_next   = 1'b1;
                status_next = ST_OUTSIDE;
                id_next     = '0;
                rstart_next = '0;
                offset_next = '0;
            end
            else
            begin
                launch = 1'b1;
            end
        end
        if (tail.vld)
        begin
            done_next         = 1'b1;
            status_next       = ST_OK;
            id_next           = tail_id;
            rstart_next       = tail.start;
            offset_next       = tail.loc - tail.start;
            cached_start_next = tail.start;
            cached_end_next   = tail.lim;
            cached_id_next    = tail_id;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (launch)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tail.vld)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:   busy = 1'b0;
            S_SEARCH: busy = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_comb
    begin
        link[0].vld   = launch;
        link[0].found = 1'b0;
        link[0].loc   = location;
        link[0].start = '0;
        link[0].lim   = '0;
        id_lk[0]      = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            logic cell_we;

            assign cell_we = we_app && (count_reg == IdW'(gi));

            lrt_cell #(
                .IdW (IdW),
                .IDX (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .we       (cell_we),
                .wdata    (sum[LocW-1:0]),
                .link_in  (link[gi]),
                .id_in    (id_lk[gi]),
                .link_out (link[gi+1]),
                .id_out   (id_lk[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            last_end_reg     <= '0;
            cached_start_reg <= '0;
            cached_end_reg   <= '0;
            cached_id_reg    <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            last_end_reg     <= last_end_next;
            cached_start_reg <= cached_start_next;
            cached_end_reg   <= cached_end_next;
            cached_id_reg    <= cached_id_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        id_reg     <= id_next;
        rstart_reg <= rstart_next;
        offset_reg <= offset_next;
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign file_id         = id_reg;
    assign range_start     = rstart_reg;
    assign offset_in_range = offset_reg;

    `LRT_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > IdW'(MAX_ENTRIES))
    `LRT_ASSERT_NEVER(a_tail_found, clk, rst_n, tail.vld && !tail.found)
    `LRT_ASSERT_NEVER(a_tail_in_search, clk, rst_n, tail.vld && (state_reg != S_SEARCH))
    `LRT_ASSERT_NEXT(a_tail_done, clk, rst_n, tail.vld, done && (status == ST_OK))
    `LRT_ASSERT_NEXT(a_append_done, clk, rst_n, accept && (req_type == REQ_APPEND), done)

endmodule
